FILE: hdl/fis_pkg.sv
// Package for the frame interval statistics block: payload structs, codes and widths.
// Used by fis_unit and frame_interval_statistics. Depends on nothing.
package fis_pkg;

  // Field widths.
  localparam int unsigned FuncW  = 3;
  localparam int unsigned TimeW  = 63;
  localparam int unsigned CountW = 32;
  localparam int unsigned MeanW  = 40;
  localparam int unsigned M2W    = 64;
  localparam int unsigned FpsW   = 32;
  localparam int unsigned RateW  = 32;

  // Shared arithmetic unit widths and step counts.
  localparam int unsigned UnitAW    = 72;
  localparam int unsigned UnitBW    = 64;
  localparam int unsigned UnitRW    = 80;
  localparam int unsigned MulW      = 40;
  localparam int unsigned CntW      = 7;
  localparam int unsigned DivSteps  = 72;
  localparam int unsigned SqrtSteps = 36;
  localparam int unsigned MulSteps  = 40;

  localparam logic [RateW-1:0] RateReset = 32'd10000000;

  // Event kinds.
  typedef enum logic [FuncW-1:0] {
    FUNC_FRAME = 3'd0,
    FUNC_TIC   = 3'd1,
    FUNC_TOC   = 3'd2,
    FUNC_PAIR  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  // Operations of the shared unit.
  typedef enum logic [1:0] {
    OP_DIV  = 2'd0,
    OP_SQRT = 2'd1,
    OP_MUL  = 2'd2
  } unit_op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_DIFF,
    ST_MDIV,
    ST_ERR,
    ST_MMUL,
    ST_REPORT,
    ST_DDIV,
    ST_DSQRT,
    ST_FMUL,
    ST_FDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [TimeW-1:0] time_now;
    logic [TimeW-1:0] meas_start;
    logic [TimeW-1:0] meas_stop;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] sample_count;
    logic [CountW-1:0] min_interval;
    logic [CountW-1:0] max_interval;
    logic [MeanW-1:0]  mean_interval;
    logic [MeanW-1:0]  deviation;
    logic [FpsW-1:0]   frames_per_second;
    logic [TimeW-1:0]  elapsed_ticks;
    logic              stats_valid;
    logic              deviation_valid;
    logic              fps_valid;
  } out_item_t;

endpackage

FILE: hdl/fis_unit.sv
// Shared iterative arithmetic unit: restoring divide, square root and shift-add multiply.
// Handles one bit (or one bit pair) per cycle. Depends on fis_pkg.
module fis_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  fis_pkg::unit_op_e            op_i,
  input  logic [fis_pkg::UnitAW-1:0]   a_i,
  input  logic [fis_pkg::UnitBW-1:0]   b_i,
  output logic                         done_o,
  output logic [fis_pkg::UnitRW-1:0]   result_o
);
  import fis_pkg::*;

  unit_op_e           op_q, op_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [UnitRW-1:0]  work_q, work_d;
  logic [UnitBW-1:0]  rem_q, rem_d;
  logic [UnitBW-1:0]  aux_q, aux_d;

  logic [UnitBW:0]    div_sh, div_diff;
  logic               div_ge;
  logic [UnitBW-1:0]  sq_sh, sq_trial, sq_diff;
  logic               sq_ge;
  logic [UnitRW-1:0]  mul_sum;

  // One step of each operation; the sequencer below picks one.
  always_comb begin
    div_sh   = {rem_q, work_q[UnitAW-1]};
    div_ge   = div_sh >= {1'b0, aux_q};
    div_diff = div_sh - {1'b0, aux_q};
    sq_sh    = {rem_q[UnitBW-3:0], work_q[UnitAW-1 -: 2]};
    sq_trial = {aux_q[UnitBW-3:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
    mul_sum  = {work_q[UnitRW-2:0], 1'b0}
             + (rem_q[MulW-1] ? {{(UnitRW-MulW){1'b0}}, aux_q[MulW-1:0]} : '0);
  end

  // Operand loading and iteration control.
  always_comb begin
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    aux_d  = aux_q;
    if (start_i) begin
      op_d   = op_i;
      busy_d = 1'b1;
      case (op_i)
        OP_MUL: begin
          work_d = '0;
          rem_d  = {{(UnitBW-MulW){1'b0}}, a_i[MulW-1:0]};
          aux_d  = b_i;
          cnt_d  = CntW'(MulSteps);
        end
        OP_SQRT: begin
          work_d = {{(UnitRW-UnitAW){1'b0}}, a_i};
          rem_d  = '0;
          aux_d  = '0;
          cnt_d  = CntW'(SqrtSteps);
        end
        default: begin
          work_d = {{(UnitRW-UnitAW){1'b0}}, a_i};
          rem_d  = '0;
          aux_d  = b_i;
          cnt_d  = CntW'(DivSteps);
        end
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        OP_MUL: begin
          work_d = mul_sum;
          rem_d  = {rem_q[UnitBW-2:0], 1'b0};
        end
        OP_SQRT: begin
          work_d = {work_q[UnitRW-3:0], 2'b00};
          rem_d  = sq_ge ? sq_diff : sq_sh;
          aux_d  = {aux_q[UnitBW-2:0], sq_ge};
        end
        default: begin
          work_d = {work_q[UnitRW-2:0], div_ge};
          rem_d  = div_ge ? div_diff[UnitBW-1:0] : div_sh[UnitBW-1:0];
        end
      endcase
    end
  end

  // Control registers reset; datapath registers do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_DIV;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      op_q   <= op_d;
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    aux_q  <= aux_d;
  end

  // Result selection.
  always_comb begin
    case (op_q)
      OP_MUL:  result_o = work_q;
      OP_SQRT: result_o = {{(UnitRW-UnitBW){1'b0}}, aux_q};
      default: result_o = {{(UnitRW-UnitAW){1'b0}}, work_q[UnitAW-1:0]};
    endcase
  end

  assign done_o = done_q;

endmodule

FILE: hdl/frame_interval_statistics.sv
// Top level of the frame interval statistics block: handshakes, statistics state, sequencer.
// Depends on fis_pkg and fis_unit.
//
//  Port group     Direction  Handshake              Payload
//  in_*           input      in_valid_i/in_ready_o   fis_pkg::in_item_t
//  out_*          output     out_valid_o/out_ready_i fis_pkg::out_item_t
//  cfg_*          input      cfg_we_i                tick rate, 32 bits
//
// A transaction that adds no interval, with the count below two, passes only through the
// event, report and done states. Adding an interval runs a 72-step divide and a 40-step
// multiply, the deviation a 72-step divide and a 36-step root, and the frame rate a 40-step
// multiply and a 72-step divide; all of it runs through the one shared unit in fis_unit.
// Reset is asynchronous and clears all statistics; the tick rate returns to 10 MHz.
// A finished result waits in the output register while the next input is accepted.
module frame_interval_statistics (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fis_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fis_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [fis_pkg::RateW-1:0]    cfg_wdata_i
);
  import fis_pkg::*;

  localparam logic [CountW-1:0] CountMax = '1;

  state_e state_q, state_d;

  // Captured transaction.
  logic [FuncW-1:0]  func_q, func_d;
  logic [TimeW-1:0]  time_q, time_d, mstart_q, mstart_d, mstop_q, mstop_d;

  // Statistics state.
  logic              armed_q, armed_d, pend_q, pend_d;
  logic [TimeW-1:0]  tic_q, tic_d, first_q, first_d, last_q, last_d;
  logic [CountW-1:0] count_q, count_d, min_q, min_d, max_q, max_d;
  logic [MeanW-1:0]  mean_q, mean_d;
  logic [M2W-1:0]    m2_q, m2_d;
  logic [RateW-1:0]  rate_q;

  // Working registers.
  logic [CountW-1:0] v_q, v_d;
  logic [MeanW-1:0]  diff_q, diff_d, dev_q, dev_d;
  logic              xge_q, xge_d, fv_q, fv_d;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic [FpsW-1:0]   fps_q, fps_d;

  // Output register.
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  // Shared unit interface.
  logic              u_start;
  unit_op_e          u_op;
  logic [UnitAW-1:0] u_a;
  logic [UnitBW-1:0] u_b;
  logic              u_done;
  logic [UnitRW-1:0] u_res;

  // Interval and helper arithmetic.
  logic [TimeW-1:0]  iv_stop, iv_start;
  logic [TimeW:0]    iv_diff;
  logic [CountW-1:0] iv_val;
  logic [MeanW-1:0]  x_val;
  logic [M2W-1:0]    m2_add;
  logic [M2W:0]      m2_sum;
  logic              do_add;

  fis_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .op_i    (u_op),
    .a_i     (u_a),
    .b_i     (u_b),
    .done_o  (u_done),
    .result_o(u_res)
  );

  // Interval of the current event: stop minus start, zero if negative, saturated.
  always_comb begin
    case (func_e'(func_q))
      FUNC_TOC: begin
        iv_stop  = time_q;
        iv_start = tic_q;
      end
      FUNC_PAIR: begin
        iv_stop  = mstop_q;
        iv_start = mstart_q;
      end
      default: begin
        iv_stop  = time_q;
        iv_start = last_q;
      end
    endcase
    iv_diff = {1'b0, iv_stop} - {1'b0, iv_start};
    if (iv_diff[TimeW])
      iv_val = '0;
    else if (iv_diff[TimeW-1:CountW] != '0)
      iv_val = CountMax;
    else
      iv_val = iv_diff[CountW-1:0];
    x_val  = {v_q, 8'b0};
    m2_add = (u_res[UnitRW-1:UnitAW] != '0) ? '1 : u_res[UnitAW-1:8];
    m2_sum = {1'b0, m2_q} + {1'b0, m2_add};
  end

  // Sequencer: next state, statistics updates and unit commands.
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    time_d      = time_q;
    mstart_d    = mstart_q;
    mstop_d     = mstop_q;
    armed_d     = armed_q;
    pend_d      = pend_q;
    tic_d       = tic_q;
    first_d     = first_q;
    last_d      = last_q;
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    mean_d      = mean_q;
    m2_d        = m2_q;
    v_d         = v_q;
    diff_d      = diff_q;
    xge_d       = xge_q;
    fv_d        = fv_q;
    elapsed_d   = elapsed_q;
    dev_d       = dev_q;
    fps_d       = fps_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    u_start     = 1'b0;
    u_op        = OP_DIV;
    u_a         = '0;
    u_b         = '0;
    do_add      = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_data_i.func;
          time_d   = in_data_i.time_now;
          mstart_d = in_data_i.meas_start;
          mstop_d  = in_data_i.meas_stop;
          state_d  = ST_EVENT;
        end
      end
      ST_EVENT: begin
        state_d = ST_REPORT;
        case (func_e'(func_q))
          FUNC_FRAME: begin
            if (armed_q) begin
              do_add = 1'b1;
              last_d = time_q;
            end else begin
              first_d = time_q;
              last_d  = time_q;
              armed_d = 1'b1;
            end
          end
          FUNC_TIC: begin
            tic_d  = time_q;
            pend_d = 1'b1;
            if (!armed_q) begin
              first_d = time_q;
              last_d  = time_q;
              armed_d = 1'b1;
            end
          end
          FUNC_TOC: begin
            if (pend_q) begin
              do_add = 1'b1;
              last_d = time_q;
              pend_d = 1'b0;
            end
          end
          FUNC_PAIR: begin
            do_add = (mstart_q != '0) && (mstop_q != '0);
          end
          FUNC_CLEAR: begin
            armed_d = 1'b0;
            pend_d  = 1'b0;
            tic_d   = '0;
            first_d = '0;
            last_d  = '0;
            count_d = '0;
            min_d   = '0;
            max_d   = '0;
            mean_d  = '0;
            m2_d    = '0;
          end
          default: ;
        endcase
        // Count, minimum and maximum update at once; the mean follows.
        if (do_add) begin
          v_d = iv_val;
          if (count_q == '0) begin
            min_d = iv_val;
            max_d = iv_val;
          end else begin
            if (iv_val < min_q) min_d = iv_val;
            if (iv_val > max_q) max_d = iv_val;
          end
          if (count_q != CountMax) count_d = count_q + CountW'(1);
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // Distance of the new sample from the mean, then divide by the count.
        xge_d   = x_val >= mean_q;
        diff_d  = (x_val >= mean_q) ? x_val - mean_q : mean_q - x_val;
        u_start = 1'b1;
        u_op    = OP_DIV;
        u_a     = {{(UnitAW-MeanW){1'b0}}, diff_d};
        u_b     = {{(UnitBW-CountW){1'b0}}, count_q};
        state_d = ST_MDIV;
      end
      ST_MDIV: begin
        if (u_done) begin
          mean_d  = xge_q ? mean_q + u_res[MeanW-1:0] : mean_q - u_res[MeanW-1:0];
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        // Product of the old and new distances feeds the squared deviation sum.
        u_start = 1'b1;
        u_op    = OP_MUL;
        u_a     = {{(UnitAW-MeanW){1'b0}}, diff_q};
        u_b     = {{(UnitBW-MeanW){1'b0}}, xge_q ? x_val - mean_q : mean_q - x_val};
        state_d = ST_MMUL;
      end
      ST_MMUL: begin
        if (u_done) begin
          m2_d    = m2_sum[M2W] ? '1 : m2_sum[M2W-1:0];
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        elapsed_d = last_q - first_q;
        fv_d      = (count_q > CountW'(1)) && (last_q != first_q);
        dev_d     = '0;
        fps_d     = '0;
        if (count_q > CountW'(1)) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = {m2_q, 8'b0};
          u_b     = {{(UnitBW-CountW){1'b0}}, count_q - CountW'(1)};
          state_d = ST_DDIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DDIV: begin
        if (u_done) begin
          u_start = 1'b1;
          u_op    = OP_SQRT;
          u_a     = u_res[UnitAW-1:0];
          state_d = ST_DSQRT;
        end
      end
      ST_DSQRT: begin
        if (u_done) begin
          dev_d = u_res[MeanW-1:0];
          if (fv_q) begin
            u_start = 1'b1;
            u_op    = OP_MUL;
            u_a     = {{(UnitAW-CountW){1'b0}}, count_q - CountW'(1)};
            u_b     = {{(UnitBW-RateW){1'b0}}, rate_q};
            state_d = ST_FMUL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FMUL: begin
        if (u_done) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = {u_res[UnitBW-1:0], 8'b0};
          u_b     = {1'b0, elapsed_q};
          state_d = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (u_done) begin
          fps_d   = (u_res[UnitAW-1:FpsW] != '0) ? '1 : u_res[FpsW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.sample_count      = count_q;
          out_d.min_interval      = min_q;
          out_d.max_interval      = max_q;
          out_d.mean_interval     = mean_q;
          out_d.deviation         = dev_q;
          out_d.frames_per_second = fps_q;
          out_d.elapsed_ticks     = elapsed_q;
          out_d.stats_valid       = count_q != '0;
          out_d.deviation_valid   = count_q > CountW'(1);
          out_d.fps_valid         = fv_q;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Statistics, configuration and output control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      pend_q      <= 1'b0;
      tic_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      rate_q      <= RateReset;
      fv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      pend_q      <= pend_d;
      tic_q       <= tic_d;
      first_q     <= first_d;
      last_q      <= last_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      fv_q        <= fv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) rate_q <= cfg_wdata_i;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    time_q    <= time_d;
    mstart_q  <= mstart_d;
    mstop_q   <= mstop_d;
    v_q       <= v_d;
    diff_q    <= diff_d;
    xge_q     <= xge_d;
    elapsed_q <= elapsed_d;
    dev_q     <= dev_d;
    fps_q     <= fps_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: dv/frame_interval_statistics_tb.sv
// Self-checking testbench for frame_interval_statistics: directed and random event
// transactions, with the expected statistics worked out by a predictor in this module.
// Depends on fis_pkg and the frame_interval_statistics RTL.
`timescale 1ns / 100ps

module frame_interval_statistics_tb;
  import fis_pkg::*;

  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [RateW-1:0] cfg_wdata = '0;

  frame_interval_statistics dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Events waiting to be sent and statistics waiting to be received.
  in_item_t  event_q[$];
  out_item_t stats_q[$];
  int unsigned errors = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  // Predicted block state.
  logic [31:0] rate_m;
  bit          armed_m, tic_pend_m;
  logic [62:0] tic_m, first_m, last_m;
  logic [63:0] count_m, min_m, max_m, mean_m, m2_m;
  logic [62:0] now_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clears the statistics; the tick rate is kept.
  function automatic void clear_stats();
    armed_m = 0; tic_pend_m = 0;
    tic_m = '0; first_m = '0; last_m = '0;
    count_m = '0; min_m = '0; max_m = '0; mean_m = '0; m2_m = '0;
  endfunction

  // Interval between two stamps, zero when negative, saturated to 32 bits.
  function automatic logic [31:0] span(logic [62:0] stop, logic [62:0] start);
    logic [62:0] d;
    d = (stop > start) ? stop - start : '0;
    return (d > 63'(Max32)) ? Max32 : d[31:0];
  endfunction

  // Welford update of count, extremes, mean and sum of squared deviations.
  function automatic void add_interval(logic [31:0] v);
    logic [63:0] x, d, e, add;
    logic [127:0] p;
    x = 64'(v) << 8;
    if (count_m == 0) begin
      min_m = 64'(v); max_m = 64'(v);
    end else begin
      if (64'(v) < min_m) min_m = 64'(v);
      if (64'(v) > max_m) max_m = 64'(v);
    end
    if (count_m < 64'(Max32)) count_m++;
    if (x >= mean_m) begin
      d = x - mean_m; mean_m = mean_m + d / count_m; e = x - mean_m;
    end else begin
      d = mean_m - x; mean_m = mean_m - d / count_m; e = mean_m - x;
    end
    mean_m &= 64'hFF_FFFF_FFFF;
    p = 128'(d) * 128'(e);
    add = (p[127:72] != 0) ? '1 : p[71:8];
    m2_m = (m2_m > ~add) ? '1 : m2_m + add;
  endfunction

  // Floor of the square root of a radicand below 2^72.
  function automatic logic [39:0] int_sqrt(logic [79:0] v);
    logic [79:0] root, rem, trial;
    root = '0; rem = '0;
    for (int i = 35; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 80'd3);
      trial = (root << 2) | 80'd1;
      if (rem >= trial) begin
        rem -= trial; root = (root << 1) | 80'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[39:0];
  endfunction

  // Applies one event and returns the statistics the block reports after it.
  function automatic out_item_t predict_stats(in_item_t it);
    out_item_t o;
    logic [62:0] el;
    logic [127:0] q;
    logic [63:0] num;
    o = '0;
    case (it.func)
      FUNC_FRAME: begin
        if (armed_m) begin
          add_interval(span(it.time_now, last_m)); last_m = it.time_now;
        end else begin
          first_m = it.time_now; last_m = it.time_now; armed_m = 1;
        end
      end
      FUNC_TIC: begin
        tic_m = it.time_now; tic_pend_m = 1;
        if (!armed_m) begin
          first_m = it.time_now; last_m = it.time_now; armed_m = 1;
        end
      end
      FUNC_TOC: begin
        if (tic_pend_m) begin
          add_interval(span(it.time_now, tic_m));
          last_m = it.time_now; tic_pend_m = 0;
        end
      end
      FUNC_PAIR: begin
        if (it.meas_start != 0 && it.meas_stop != 0)
          add_interval(span(it.meas_stop, it.meas_start));
      end
      FUNC_CLEAR: clear_stats();
      default: ;
    endcase
    el = last_m - first_m;
    o.sample_count    = count_m[31:0];
    o.elapsed_ticks   = el;
    o.stats_valid     = (count_m >= 1);
    o.deviation_valid = (count_m >= 2);
    o.fps_valid       = (count_m >= 2) && (el != 0);
    if (o.stats_valid) begin
      o.min_interval  = min_m[31:0];
      o.max_interval  = max_m[31:0];
      o.mean_interval = mean_m[39:0];
    end
    if (o.deviation_valid) begin
      q = (128'(m2_m) << 8) / 128'(count_m - 1);
      o.deviation = int_sqrt(q[79:0]);
    end
    if (o.fps_valid) begin
      num = 64'(rate_m) * (count_m - 1);
      q = (128'(num) << 8) / 128'(el);
      o.frames_per_second = (q > 128'(Max32)) ? Max32 : q[31:0];
    end
    return o;
  endfunction

  // Driver: presents queued events and predicts each accepted transaction.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) stats_q.push_back(predict_stats(in_data));
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          in_data  <= event_q.pop_front();
          in_valid <= 1'b1;
          send_gap = send_idle ? $urandom_range(0, 6) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: stalls the result channel at random and checks each transaction.
  int unsigned recv_stall = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        recv_stall = recv_idle ? $urandom_range(0, 6) : 0;
        if (stats_q.size() == 0) begin
          $error("statistics transaction with nothing expected");
          errors++;
        end else begin
          e = stats_q.pop_front();
          check_field("sample_count", 64'(e.sample_count), 64'(out_data.sample_count));
          check_field("min_interval", 64'(e.min_interval), 64'(out_data.min_interval));
          check_field("max_interval", 64'(e.max_interval), 64'(out_data.max_interval));
          check_field("mean_interval", 64'(e.mean_interval),
                      64'(out_data.mean_interval));
          check_field("deviation", 64'(e.deviation), 64'(out_data.deviation));
          check_field("frames_per_second", 64'(e.frames_per_second),
                      64'(out_data.frames_per_second));
          check_field("elapsed_ticks", 64'(e.elapsed_ticks),
                      64'(out_data.elapsed_ticks));
          check_field("stats_valid", 64'(e.stats_valid), 64'(out_data.stats_valid));
          check_field("deviation_valid", 64'(e.deviation_valid),
                      64'(out_data.deviation_valid));
          check_field("fps_valid", 64'(e.fps_valid), 64'(out_data.fps_valid));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic void queue_event(func_e f, logic [62:0] t, logic [62:0] a,
                                      logic [62:0] b);
    in_item_t it;
    it.func = f; it.time_now = t; it.meas_start = a; it.meas_stop = b;
    event_q.push_back(it);
  endfunction

  // Mostly small steps, sometimes none, sometimes a jump past 32 bits.
  function automatic logic [62:0] step_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return rand63() >> $urandom_range(0, 40);
    return 63'($urandom_range(1, 5000));
  endfunction

  // One random event; most form well-formed frame, tic/toc and pair sequences.
  function automatic void queue_random();
    int unsigned r;
    logic [62:0] a;
    in_item_t it;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      now_t += step_ticks(); queue_event(FUNC_FRAME, now_t, rand63(), rand63());
    end else if (r < 55) begin
      now_t += step_ticks(); queue_event(FUNC_TIC, now_t, rand63(), rand63());
    end else if (r < 70) begin
      now_t += step_ticks(); queue_event(FUNC_TOC, now_t, rand63(), rand63());
    end else if (r < 85) begin
      a = ($urandom_range(0, 9) == 0) ? rand63() : now_t + 1;
      case ($urandom_range(0, 9))
        0: queue_event(FUNC_PAIR, rand63(), '0, a + step_ticks());
        1: queue_event(FUNC_PAIR, rand63(), a, '0);
        2: queue_event(FUNC_PAIR, rand63(), a + step_ticks(), a);
        default: queue_event(FUNC_PAIR, rand63(), a, a + step_ticks());
      endcase
    end else if (r < 88) begin
      queue_event(FUNC_CLEAR, rand63(), rand63(), rand63());
    end else begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it.func = 3'($urandom_range(0, 7));
      event_q.push_back(it);
    end
  endfunction

  task automatic wait_idle();
    while (event_q.size() != 0 || in_valid || stats_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [31:0] r);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    rate_m = r;
  endtask

  // Stimulus: directed events, then random phases under several tick rates.
  initial begin
    logic [31:0] rates[5];
    logic [62:0] top;
    rate_m = RateReset;
    clear_stats();
    now_t = 63'd1000;
    top = '1;
    rates = '{32'd1, Max32, 32'd0, $urandom, $urandom_range(1000, 100000)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: arming, negative and saturated intervals, toc without tic,
    // tic replacing a pending tic, ignored pairs, overflowing sums, unused codes.
    queue_event(FUNC_TOC, 63'd50, '0, '0);
    queue_event(FUNC_FRAME, 63'd100, '0, '0);
    queue_event(FUNC_FRAME, 63'd1100, '0, '0);
    queue_event(FUNC_FRAME, 63'd900, '0, '0);
    queue_event(FUNC_FRAME, 63'd2000, top, top);
    queue_event(FUNC_TIC, 63'd2100, '0, '0);
    queue_event(FUNC_TIC, 63'd2200, '0, '0);
    queue_event(FUNC_TOC, 63'd2250, '0, '0);
    queue_event(FUNC_TOC, 63'd2300, '0, '0);
    queue_event(FUNC_PAIR, '0, '0, 63'd10);
    queue_event(FUNC_PAIR, '0, 63'd10, '0);
    queue_event(FUNC_PAIR, '0, 63'd20, 63'd10);
    queue_event(FUNC_PAIR, '0, 63'd1, top);
    queue_event(FUNC_PAIR, '0, 63'd1, 63'd2);
    queue_event(FUNC_PAIR, '0, 63'd1, top);
    queue_event(FUNC_FRAME, top, '0, '0);
    queue_event(func_e'(3'd5), top, top, top);
    queue_event(func_e'(3'd6), '0, '0, '0);
    queue_event(func_e'(3'd7), 63'h5555_5555_5555_5555, '0, top);
    queue_event(FUNC_CLEAR, '0, '0, '0);
    queue_event(FUNC_TIC, top, '0, '0);
    queue_event(FUNC_TOC, 63'd5, '0, '0);
    queue_event(FUNC_FRAME, 63'd7, '0, '0);
    queue_event(FUNC_CLEAR, top, top, top);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph != 2);
      recv_idle = (ph != 3);
      if (ph > 0) write_rate(rates[ph - 1]);
      for (int k = 0; k < 75; k++) begin
        queue_random();
        // Let the sender drain and then pause until every expected result is back.
        if (ph == 4 && k == 30) begin
          while (event_q.size() != 0 || in_valid || stats_q.size() != 0) begin
            @(posedge clk_i);
          end
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("frame_interval_statistics_tb: done, clean");
    end else begin
      $display("frame_interval_statistics_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15_000_000;
    $display("frame_interval_statistics_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hdl/fis_pkg.sv
hdl/fis_unit.sv
hdl/frame_interval_statistics.sv
dv/frame_interval_statistics_tb.sv
